// ===== src/u8sv_pkg.sv =====
// ----------------------------------------------------------------------------
// u8sv_pkg
// Shared types and constants for the UTF-8 stream validator.
// ----------------------------------------------------------------------------
package u8sv_pkg;

    localparam int unsigned IN_DATA_W  = 8;
    localparam int unsigned OUT_DATA_W = 8;
    localparam int unsigned CP_W       = 21;

    typedef enum logic [2:0] {
        FAULT_NONE      = 3'd0,
        FAULT_LEAD      = 3'd1,
        FAULT_CONT      = 3'd2,
        FAULT_TRUNC     = 3'd3,
        FAULT_OVERLONG  = 3'd4,
        FAULT_SURROGATE = 3'd5,
        FAULT_ABOVE     = 3'd6
    } fault_t;

    typedef struct packed {
        logic [IN_DATA_W-1:0] data_byte;
        logic                 last_byte;
        logic                 empty_string;
    } in_word_t;

    typedef struct packed {
        fault_t fault_kind;
        logic   string_valid;
    } verdict_t;

    localparam logic [CP_W-1:0] CP_MIN_3B    = 21'h000800;
    localparam logic [CP_W-1:0] CP_MIN_4B    = 21'h010000;
    localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [CP_W-1:0] CP_MAX       = 21'h10FFFF;

endpackage

// ===== src/u8sv_in_reg.sv =====
// ----------------------------------------------------------------------------
// u8sv_in_reg
// Input register stage: captures one byte word and holds it until the
// decoder takes it.
// ----------------------------------------------------------------------------
module u8sv_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  u8sv_pkg::in_word_t in_word,
    output logic              held_valid,
    input  logic              take,
    output u8sv_pkg::in_word_t held_word
);

    logic              valid_reg;
    logic              valid_next;
    u8sv_pkg::in_word_t word_reg;

    assign in_ready   = !valid_reg || take;
    assign held_valid = valid_reg;
    assign held_word  = word_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_valid && in_ready)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            word_reg <= in_word;
        end
    end

endmodule

// ===== src/u8sv_decode.sv =====
// ----------------------------------------------------------------------------
// u8sv_decode
// Per-byte UTF-8 decode step with the string state registers; flags a
// verdict when a string ends.
// ----------------------------------------------------------------------------
module u8sv_decode (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  u8sv_pkg::in_word_t word,
    output logic               verdict_valid,
    output u8sv_pkg::verdict_t verdict
);

    logic [1:0]                  pend_reg;
    logic [1:0]                  pend_next;
    logic [1:0]                  extra_reg;
    logic [1:0]                  extra_next;
    logic [u8sv_pkg::CP_W-1:0]   cp_reg;
    logic [u8sv_pkg::CP_W-1:0]   cp_next;
    u8sv_pkg::fault_t            fault_reg;
    u8sv_pkg::fault_t            fault_next;
    logic [u8sv_pkg::CP_W-1:0]   cp_shift;
    logic [7:0]                  b;

    function automatic u8sv_pkg::fault_t check_cp(input logic [1:0] extra,
                                                 input logic [u8sv_pkg::CP_W-1:0] cp);
        u8sv_pkg::fault_t f;
        f = u8sv_pkg::FAULT_NONE;
        if ((extra == 2'd2 && cp < u8sv_pkg::CP_MIN_3B) ||
            (extra == 2'd3 && cp < u8sv_pkg::CP_MIN_4B))
        begin
            f = u8sv_pkg::FAULT_OVERLONG;
        end
        else if (cp >= u8sv_pkg::CP_SURR_LO && cp <= u8sv_pkg::CP_SURR_HI)
        begin
            f = u8sv_pkg::FAULT_SURROGATE;
        end
        else if (cp > u8sv_pkg::CP_MAX)
        begin
            f = u8sv_pkg::FAULT_ABOVE;
        end
        return f;
    endfunction

    assign b        = word.data_byte;
    assign cp_shift = {cp_reg[u8sv_pkg::CP_W-7:0], b[5:0]};

    always_comb
    begin
        pend_next     = pend_reg;
        extra_next    = extra_reg;
        cp_next       = cp_reg;
        fault_next    = fault_reg;
        verdict_valid = 1'b0;
        verdict       = '{fault_kind: u8sv_pkg::FAULT_NONE, string_valid: 1'b1};

        if (!word.empty_string)
        begin
            if (fault_reg != u8sv_pkg::FAULT_NONE)
            begin
                if (pend_reg != 2'd0)
                begin
                    pend_next = pend_reg - 2'd1;
                end
            end
            else if (pend_reg == 2'd0)
            begin
                unique case (b) inside
                    [8'h01:8'h7F]:
                    begin
                        extra_next = 2'd0;
                        cp_next    = {13'd0, b};
                    end
                    [8'hC2:8'hDF]:
                    begin
                        extra_next = 2'd1;
                        cp_next    = {16'd0, b[4:0]};
                    end
                    [8'hE0:8'hEF]:
                    begin
                        extra_next = 2'd2;
                        cp_next    = {17'd0, b[3:0]};
                    end
                    [8'hF0:8'hF4]:
                    begin
                        extra_next = 2'd3;
                        cp_next    = {18'd0, b[2:0]};
                    end
                    default:
                    begin
                        extra_next = 2'd0;
                        cp_next    = '0;
                        fault_next = u8sv_pkg::FAULT_LEAD;
                    end
                endcase
                pend_next = (fault_next == u8sv_pkg::FAULT_NONE) ? extra_next : pend_reg;
            end
            else
            begin
                pend_next = pend_reg - 2'd1;
                if (b[7:6] != 2'b10)
                begin
                    fault_next = u8sv_pkg::FAULT_CONT;
                end
                else
                begin
                    cp_next = cp_shift;
                    if (pend_next == 2'd0)
                    begin
                        fault_next = check_cp(extra_reg, cp_shift);
                    end
                end
            end
        end

        if (word.empty_string || word.last_byte)
        begin
            verdict_valid = 1'b1;
            if (pend_next != 2'd0)
            begin
                fault_next = u8sv_pkg::FAULT_TRUNC;
            end
            verdict.fault_kind   = fault_next;
            verdict.string_valid = (fault_next == u8sv_pkg::FAULT_NONE);
            pend_next            = 2'd0;
            extra_next           = 2'd0;
            cp_next              = '0;
            fault_next           = u8sv_pkg::FAULT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg  <= 2'd0;
            extra_reg <= 2'd0;
            cp_reg    <= '0;
            fault_reg <= u8sv_pkg::FAULT_NONE;
        end
        else if (step)
        begin
            pend_reg  <= pend_next;
            extra_reg <= extra_next;
            cp_reg    <= cp_next;
            fault_reg <= fault_next;
        end
    end

`ifndef SYNTHESIS
    // state is clean after a verdict
    a_clear_after_verdict: assert property (@(posedge clk) disable iff (!rst_n)
        (step && verdict_valid) |=> (pend_reg == 2'd0 && extra_reg == 2'd0 &&
                                     fault_reg == u8sv_pkg::FAULT_NONE))
        else $error("state not cleared after verdict");

    a_pend_le_extra: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= extra_reg)
        else $error("pending count exceeds sequence length");

    // first fault is sticky within a string
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        (step && !verdict_valid && fault_reg != u8sv_pkg::FAULT_NONE)
            |=> (fault_reg == $past(fault_reg)))
        else $error("first fault overwritten");
`endif

endmodule

// ===== src/u8sv_out_reg.sv =====
// ----------------------------------------------------------------------------
// u8sv_out_reg
// Result register: holds one verdict word until the sink takes it.
// ----------------------------------------------------------------------------
module u8sv_out_reg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           load,
    input  u8sv_pkg::verdict_t             verdict,
    output logic                           free,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [u8sv_pkg::OUT_DATA_W-1:0] out_data
);

    logic                           valid_reg;
    logic                           valid_next;
    logic [u8sv_pkg::OUT_DATA_W-1:0] data_reg;

    assign free      = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= {{(u8sv_pkg::OUT_DATA_W - 4){1'b0}}, verdict};
        end
    end

endmodule

// ===== src/utf8_stream_validator_top.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_validator_top
// Streaming UTF-8 well-formedness checker with one verdict word per string.
// ----------------------------------------------------------------------------
// Takes one byte word per cycle while the sink keeps the result register free,
// and returns one verdict word per string for the word that ends it (tlast
// byte or tuser empty string). The byte goes through an input register, a
// single decode step that updates the per-string state, and a result
// register; the decode state loop sets the rate at one byte per clock. Words
// that end no string produce no output. A verdict carries string_valid and the
// first fault found, or 3 if the string is truncated: 1 bad lead, 2 bad
// continuation, 3 truncated, 4 overlong, 5 surrogate, 6 above 0x10FFFF.
module utf8_stream_validator_top (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] empty_string
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] string_valid, [3:1] fault_kind, [7:4] zero
);

    u8sv_pkg::in_word_t in_word;
    u8sv_pkg::in_word_t held_word;
    u8sv_pkg::verdict_t verdict;
    logic               held_valid;
    logic               out_free;
    logic               advance;
    logic               verdict_valid;

    assign in_word = '{data_byte: s_axis_tdata, last_byte: s_axis_tlast,
                       empty_string: s_axis_tuser};
    assign advance = held_valid && out_free;

    u8sv_in_reg u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .in_word    (in_word),
        .held_valid (held_valid),
        .take       (advance),
        .held_word  (held_word)
    );

    u8sv_decode u_dec (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (advance),
        .word          (held_word),
        .verdict_valid (verdict_valid),
        .verdict       (verdict)
    );

    u8sv_out_reg u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && verdict_valid),
        .verdict   (verdict),
        .free      (out_free),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata)
    );

endmodule
